/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Overlapping implication checked outside reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/grmbx_pkg.sv */
// ----------------------------------------------------------------------------
// grmbx_pkg
// Constants, operation and status codes, and shared types of the mailbox.
// ----------------------------------------------------------------------------
package grmbx_pkg;

	localparam int INSTANCES    = 4;
	localparam int QUEUE_DEPTH  = 8;
	localparam int PAYLOAD_BITS = 64;

	localparam int STORE_SIZE = INSTANCES * QUEUE_DEPTH;
	localparam int INST_W     = (INSTANCES > 1) ? $clog2(INSTANCES) : 1;
	localparam int PTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int ADDR_W     = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;

	localparam int MODE_W   = 3;
	localparam int STATUS_W = 3;
	localparam int GEN_W    = 32;
	localparam int IREQ_W   = 2;
	localparam int DATA_W   = 64;

	localparam logic [GEN_W-1:0] GEN_MAX = '1;

	// Operation codes
	localparam logic [MODE_W-1:0] MODE_PUBLISH     = 3'd0;
	localparam logic [MODE_W-1:0] MODE_COPY        = 3'd1;
	localparam logic [MODE_W-1:0] MODE_QUERY       = 3'd2;
	localparam logic [MODE_W-1:0] MODE_ADVERTISE   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_UNADVERTISE = 3'd4;
	localparam logic [MODE_W-1:0] MODE_CLAIM       = 3'd5;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_INST = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_ADV  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NO_NEW   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_ALREADY  = 3'd4;
	localparam logic [STATUS_W-1:0] ST_NONE     = 3'd5;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd6;

	// Decoded operation handed from the controller to the datapath.
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [GEN_W-1:0]    gen_out;
		logic [IREQ_W-1:0]   inst_out;
		logic                wr_en;
		logic                rd_en;
		logic [ADDR_W-1:0]   addr;
	} op_t;

endpackage

/* rtl/grmbx_ram.sv */
// ----------------------------------------------------------------------------
// grmbx_ram
// Single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module grmbx_ram #(
	parameter int DEPTH  = 32,
	parameter int WIDTH  = 64,
	parameter int ADDR_W = 5
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] addr,
	input  logic [WIDTH-1:0]  wdata,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/grmbx_ctrl.sv */
// ----------------------------------------------------------------------------
// grmbx_ctrl
// Per-instance counters, write pointers and advertised flags, and the decode
// of one operation into a result and a ring access.
// ----------------------------------------------------------------------------
module grmbx_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                accept,
	input  logic [grmbx_pkg::MODE_W-1:0]        mode,
	input  logic [grmbx_pkg::IREQ_W-1:0]        instance_req,
	input  logic [grmbx_pkg::GEN_W-1:0]         reader_generation,
	output grmbx_pkg::op_t                      op
);

	logic [grmbx_pkg::GEN_W-1:0] gen_q [grmbx_pkg::INSTANCES];
	logic [grmbx_pkg::PTR_W-1:0] ptr_q [grmbx_pkg::INSTANCES];
	logic [grmbx_pkg::INSTANCES-1:0] adv_q;

	logic [grmbx_pkg::INST_W-1:0] inst_idx;
	logic                         inst_ok;
	logic [grmbx_pkg::GEN_W-1:0]  newest;
	logic [grmbx_pkg::PTR_W-1:0]  wr_ptr;
	logic                         adv_cur;
	logic [grmbx_pkg::GEN_W-1:0]  oldest;
	logic [grmbx_pkg::GEN_W-1:0]  target;
	logic [grmbx_pkg::PTR_W-1:0]  lag;
	logic [grmbx_pkg::PTR_W:0]    slot_sum;
	logic [grmbx_pkg::PTR_W-1:0]  rd_slot;
	logic [grmbx_pkg::ADDR_W-1:0] base;
	logic                         claim_found;
	logic [grmbx_pkg::INST_W-1:0] claim_idx;
	logic                         do_publish;
	logic                         do_set_adv;
	logic                         do_clr_adv;

	assign inst_idx = grmbx_pkg::INST_W'(instance_req);
	assign inst_ok  = (32'(instance_req) < grmbx_pkg::INSTANCES);
	assign newest   = inst_ok ? gen_q[inst_idx] : '0;
	assign wr_ptr   = inst_ok ? ptr_q[inst_idx] : '0;
	assign adv_cur  = inst_ok ? adv_q[inst_idx] : 1'b0;
	assign base     = grmbx_pkg::ADDR_W'(32'(inst_idx) * grmbx_pkg::QUEUE_DEPTH);

	// Oldest generation still held by the ring, and the one the reader gets.
	always_comb begin
		if (newest > grmbx_pkg::GEN_W'(grmbx_pkg::QUEUE_DEPTH)) begin
			oldest = newest - grmbx_pkg::GEN_W'(grmbx_pkg::QUEUE_DEPTH) + 1'b1;
		end else begin
			oldest = grmbx_pkg::GEN_W'(1);
		end
		if (reader_generation == '0 || reader_generation > newest ||
				reader_generation < oldest - 1'b1) begin
			target = oldest;
		end else begin
			target = reader_generation + 1'b1;
		end
	end

	// The slot of generation target sits lag places behind the newest slot.
	assign lag      = grmbx_pkg::PTR_W'(newest - target);
	assign slot_sum = (grmbx_pkg::PTR_W+1)'(wr_ptr)
		+ (grmbx_pkg::PTR_W+1)'(grmbx_pkg::QUEUE_DEPTH - 1)
		- (grmbx_pkg::PTR_W+1)'(lag);
	assign rd_slot  = (slot_sum >= (grmbx_pkg::PTR_W+1)'(grmbx_pkg::QUEUE_DEPTH))
		? grmbx_pkg::PTR_W'(slot_sum - (grmbx_pkg::PTR_W+1)'(grmbx_pkg::QUEUE_DEPTH))
		: grmbx_pkg::PTR_W'(slot_sum);

	// First instance that is not advertised.
	always_comb begin
		claim_found = 1'b0;
		claim_idx   = '0;
		for (int i = 0; i < grmbx_pkg::INSTANCES; i++) begin
			if (!claim_found && !adv_q[i]) begin
				claim_found = 1'b1;
				claim_idx   = grmbx_pkg::INST_W'(i);
			end
		end
	end

	always_comb begin
		op          = '0;
		op.status   = grmbx_pkg::ST_BAD_INST;
		do_publish  = 1'b0;
		do_set_adv  = 1'b0;
		do_clr_adv  = 1'b0;
		if (mode == grmbx_pkg::MODE_CLAIM) begin
			if (claim_found) begin
				op.status   = grmbx_pkg::ST_OK;
				op.inst_out = grmbx_pkg::IREQ_W'(claim_idx);
			end else begin
				op.status = grmbx_pkg::ST_NONE;
			end
		end else if (inst_ok) begin
			case (mode)
				grmbx_pkg::MODE_PUBLISH: begin
					op.addr = base + grmbx_pkg::ADDR_W'(wr_ptr);
					if (!adv_cur) begin
						op.status = grmbx_pkg::ST_NOT_ADV;
					end else if (newest == grmbx_pkg::GEN_MAX) begin
						op.status = grmbx_pkg::ST_FULL;
					end else begin
						op.status  = grmbx_pkg::ST_OK;
						op.wr_en   = 1'b1;
						do_publish = 1'b1;
					end
				end
				grmbx_pkg::MODE_COPY: begin
					op.addr = base + grmbx_pkg::ADDR_W'(rd_slot);
					if (newest == '0) begin
						op.status = grmbx_pkg::ST_NO_NEW;
					end else if (newest == reader_generation) begin
						op.status  = grmbx_pkg::ST_NO_NEW;
						op.gen_out = reader_generation;
					end else begin
						op.status  = grmbx_pkg::ST_OK;
						op.gen_out = target;
						op.rd_en   = 1'b1;
					end
				end
				grmbx_pkg::MODE_QUERY: begin
					op.status  = (newest != reader_generation)
						? grmbx_pkg::ST_OK : grmbx_pkg::ST_NO_NEW;
					op.gen_out = reader_generation;
				end
				grmbx_pkg::MODE_ADVERTISE: begin
					if (adv_cur) begin
						op.status = grmbx_pkg::ST_ALREADY;
					end else begin
						op.status  = grmbx_pkg::ST_OK;
						do_set_adv = 1'b1;
					end
				end
				grmbx_pkg::MODE_UNADVERTISE: begin
					op.status  = grmbx_pkg::ST_OK;
					do_clr_adv = 1'b1;
				end
				default: begin
					op.status = grmbx_pkg::ST_BAD_INST;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adv_q <= '0;
			for (int i = 0; i < grmbx_pkg::INSTANCES; i++) begin
				gen_q[i] <= '0;
				ptr_q[i] <= '0;
			end
		end else if (accept) begin
			if (do_publish) begin
				gen_q[inst_idx] <= newest + 1'b1;
				ptr_q[inst_idx] <= (32'(wr_ptr) == grmbx_pkg::QUEUE_DEPTH - 1)
					? '0 : wr_ptr + 1'b1;
			end
			if (do_set_adv) begin
				adv_q[inst_idx] <= 1'b1;
			end
			if (do_clr_adv) begin
				adv_q[inst_idx] <= 1'b0;
			end
			if (mode == grmbx_pkg::MODE_CLAIM && claim_found) begin
				adv_q[claim_idx] <= 1'b1;
			end
		end
	end

endmodule

/* rtl/generation_ring_mailbox_top.sv */
// ----------------------------------------------------------------------------
// generation_ring_mailbox_top
// Multi-instance mailbox of overwriting rings with generation counters.
// ----------------------------------------------------------------------------
// The mailbox takes one operation beat per clock cycle while in_ready is high
// and returns exactly one result beat for it through the read stage and output
// register. Every operation makes at most one access to the ring RAM (a write
// for a publish, a read for a copy), and that single RAM port is what sets the
// rate of one operation per cycle. Generation counters, write pointers and
// advertised flags live in flip-flops and are updated at the accepting edge,
// so the next operation already sees them; the ring RAM holds data only and
// needs no clearing after reset, since a copy never reads a slot that has not
// been published. A result beat waiting on out_ready holds the output
// register while one more operation may sit in the read stage; further input
// is held off with in_ready low until the output drains.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module generation_ring_mailbox_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [grmbx_pkg::MODE_W-1:0]         mode,
	input  logic [grmbx_pkg::IREQ_W-1:0]         instance_req,
	input  logic [grmbx_pkg::GEN_W-1:0]          reader_generation,
	input  logic [grmbx_pkg::DATA_W-1:0]         payload,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [grmbx_pkg::STATUS_W-1:0]       status,
	output logic [grmbx_pkg::GEN_W-1:0]          generation_out,
	output logic [grmbx_pkg::DATA_W-1:0]         payload_out,
	output logic [grmbx_pkg::IREQ_W-1:0]         instance_out
);

	grmbx_pkg::op_t op;

	logic                                accept;
	logic                                rd_fire;
	logic [grmbx_pkg::PAYLOAD_BITS-1:0]  rdata;

	// Read stage: result fields wait here for the RAM read data.
	logic                                s1_valid;
	logic                                s1_rd;
	logic [grmbx_pkg::STATUS_W-1:0]      s1_status;
	logic [grmbx_pkg::GEN_W-1:0]         s1_gen;
	logic [grmbx_pkg::IREQ_W-1:0]        s1_inst;
	logic                                s1_adv;

	// Output register.
	logic                                out_valid_q;
	logic [grmbx_pkg::STATUS_W-1:0]      status_q;
	logic [grmbx_pkg::GEN_W-1:0]         gen_q;
	logic [grmbx_pkg::DATA_W-1:0]        payload_q;
	logic [grmbx_pkg::IREQ_W-1:0]        inst_q;

	// The read stage moves on whenever the output register is free or drains.
	assign s1_adv   = s1_valid && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid || s1_adv;
	assign accept   = in_valid && in_ready;
	assign rd_fire  = accept && op.rd_en;

	grmbx_ctrl u_ctrl (
		.clk               (clk),
		.arst_n            (arst_n),
		.accept            (accept),
		.mode              (mode),
		.instance_req      (instance_req),
		.reader_generation (reader_generation),
		.op                (op)
	);

	// The read data register only loads on a copy, so it holds while the
	// read stage is stalled.
	grmbx_ram #(
		.DEPTH  (grmbx_pkg::STORE_SIZE),
		.WIDTH  (grmbx_pkg::PAYLOAD_BITS),
		.ADDR_W (grmbx_pkg::ADDR_W)
	) u_ring (
		.clk   (clk),
		.wr_en (accept && op.wr_en),
		.rd_en (rd_fire),
		.addr  (op.addr),
		.wdata (payload[grmbx_pkg::PAYLOAD_BITS-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (accept) begin
			s1_valid <= 1'b1;
		end else if (s1_adv) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_rd     <= op.rd_en;
			s1_status <= op.status;
			s1_gen    <= op.gen_out;
			s1_inst   <= op.inst_out;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Only a successful copy carries a data word; everything else reads zero.
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			status_q  <= s1_status;
			gen_q     <= s1_gen;
			inst_q    <= s1_inst;
			payload_q <= s1_rd ? grmbx_pkg::DATA_W'(rdata) : '0;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign generation_out = gen_q;
	assign payload_out    = payload_q;
	assign instance_out   = inst_q;

	`ASSERT_NEXT(a_read_lands_in_s1, rd_fire, s1_valid && s1_rd, "RAM read lost its stage")
	`ASSERT_IMPLIES(a_fail_no_data, out_valid && status != grmbx_pkg::ST_OK, payload_out == '0, "data on failed result")
	`ASSERT_NEXT(a_s1_holds, s1_valid && !s1_adv, s1_valid && $stable(s1_gen) && $stable(s1_status), "read stage lost a stalled beat")
	`ASSERT_IMPLIES(a_s1_read_ok, s1_valid && s1_rd, s1_status == grmbx_pkg::ST_OK, "RAM read on failed copy")

endmodule
